// ===== rtl/ilp_pkg.sv =====
`timescale 1ns / 1ps
package ilp_pkg;

   localparam int DEF_MAX_LEADING  = 18;
   localparam int DEF_MAX_FRACTION = 6;

   localparam int CSR_AW = 4;
   localparam int CSR_DW = 32;

   localparam logic [1:0] REG_START_FIELD        = 2'd0;
   localparam logic [1:0] REG_END_FIELD          = 2'd1;
   localparam logic [1:0] REG_LEADING_PRECISION  = 2'd2;
   localparam logic [1:0] REG_FRACTION_PRECISION = 2'd3;

   localparam logic [2:0] RST_START_FIELD        = 3'd0;
   localparam logic [2:0] RST_END_FIELD          = 3'd0;
   localparam logic [4:0] RST_LEADING_PRECISION  = 5'd2;
   localparam logic [2:0] RST_FRACTION_PRECISION = 3'd0;

   localparam logic [2:0] FIELD_YEAR     = 3'd0;
   localparam logic [2:0] FIELD_MONTH    = 3'd1;
   localparam logic [2:0] FIELD_DAY      = 3'd2;
   localparam logic [2:0] FIELD_HOUR     = 3'd3;
   localparam logic [2:0] FIELD_MINUTE   = 3'd4;
   localparam logic [2:0] FIELD_SECOND   = 3'd5;
   localparam logic [2:0] FIELD_FRACTION = 3'd6;

   localparam logic [7:0] CHAR_NUL   = 8'h00;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_PLUS  = 8'h2b;
   localparam logic [7:0] CHAR_MINUS = 8'h2d;
   localparam logic [7:0] CHAR_DOT   = 8'h2e;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_COLON = 8'h3a;
   localparam logic [7:0] CHAR_CARET = 8'h5e;

   typedef enum logic [3:0] {
      PH_START,
      PH_BLANK1,
      PH_BLANK2,
      PH_LEAD,
      PH_PUNCT,
      PH_FIELD,
      PH_FRACSEL,
      PH_FRACFIRST,
      PH_FRAC,
      PH_TRAIL
   } phase_type;

   typedef struct packed {
      logic [7:0] text_char;
      logic [7:0] sign_char;
   } req_payload_type;

   typedef struct packed {
      logic signed [63:0] interval_count;
      logic               is_valid;
   } rsp_payload_type;

   function automatic logic [6:0] field_max(input logic [2:0] field);
      case (field)
         FIELD_MONTH:                 field_max = 7'd11;
         FIELD_HOUR:                  field_max = 7'd23;
         FIELD_MINUTE, FIELD_SECOND:  field_max = 7'd59;
         default:                     field_max = 7'd0;
      endcase
   endfunction

   function automatic logic [7:0] field_punc(input logic [2:0] field);
      case (field)
         FIELD_MONTH:                 field_punc = CHAR_MINUS;
         FIELD_HOUR:                  field_punc = CHAR_SPACE;
         FIELD_MINUTE, FIELD_SECOND:  field_punc = CHAR_COLON;
         default:                     field_punc = CHAR_CARET;
      endcase
   endfunction

   function automatic logic [23:0] pow10(input logic [2:0] k);
      case (k)
         3'd0:    pow10 = 24'd1;
         3'd1:    pow10 = 24'd10;
         3'd2:    pow10 = 24'd100;
         3'd3:    pow10 = 24'd1000;
         3'd4:    pow10 = 24'd10000;
         3'd5:    pow10 = 24'd100000;
         3'd6:    pow10 = 24'd1000000;
         default: pow10 = 24'd10000000;
      endcase
   endfunction

endpackage

// ===== rtl/interval_literal_parser.sv =====
`timescale 1ns / 1ps
// interval literal parser
// req channel: one beat per literal character (text_char) with sign_char, which is
// sampled on the first character of a literal; a text_char of zero ends the literal.
// rsp channel: one beat per terminator, carrying the signed count in units of the
// end field (fraction scaled, modulo 2^64) and is_valid; the count is 0 when invalid.
// csr port: apb-style, start_field at 0x0, end_field at 0x4, leading_precision at
// 0x8, fraction_precision at 0xc; always ready, reads return the register value.
// throughput: one character per cycle while req_stall is low; the parser folds each
// character into its state with at most one multiply-add, by 10 or by a field's range.
// result path: the terminator beat is registered in the first stage behind the parser;
// the stages after it are negate, fraction-scale partial products, and the final add
// into the output register.
// when the receiver stalls, the pipeline keeps filling until every stage holds a
// beat; req_stall rises only when the first stage behind the parser is full and
// cannot move.
// reset: registers return to 0, 0, 2, 0, the parser waits for the start of a
// literal and the pipeline is empty.
module interval_literal_parser
   import ilp_pkg::*;
#(
   parameter int MAX_LEADING  = DEF_MAX_LEADING,
   parameter int MAX_FRACTION = DEF_MAX_FRACTION
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  req_payload_type     req_payload,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output rsp_payload_type     rsp_payload,
   input  logic                csr_psel,
   input  logic                csr_penable,
   input  logic                csr_pwrite,
   input  logic [CSR_AW-1:0]   csr_paddr,
   input  logic [CSR_DW-1:0]   csr_pwdata,
   output logic [CSR_DW-1:0]   csr_prdata,
   output logic                csr_pready
);

   localparam int FDW = $clog2(MAX_FRACTION + 1);

   logic [2:0] start_field_ff, end_field_ff, fraction_precision_ff;
   logic [4:0] leading_precision_ff;

   phase_type     phase_ff, phase_in;
   logic [63:0]   accum_ff, accum_in;
   logic [2:0]    field_index_ff, field_index_in;
   logic [6:0]    field_value_ff, field_value_in;
   logic [4:0]    digit_count_ff, digit_count_in;
   logic [FDW-1:0] fraction_digits_ff, fraction_digits_in;
   logic          is_negative_ff, is_negative_in;
   logic          failed_ff, failed_in;
   logic [2:0]    scale_ff, scale_in;

   logic          qual_ok;
   logic [5:0]    prec;
   logic          pair_ok;

   logic          mul_en;
   logic [5:0]    mul_k;
   logic [6:0]    mul_add;
   logic          done;
   logic          lead_go;
   logic          fields_go;
   logic          frac_allowed;
   logic [7:0]    c;
   logic [7:0]    sgn;
   logic          c_blank, c_digit;

   logic          req_accept, term_beat, csr_write;
   logic          rdy1, rdy2, rdy3, rdy4;

   logic          s1_valid_ff, s1_neg_ff, s1_ok_ff;
   logic [63:0]   s1_accum_ff;
   logic [2:0]    s1_scale_ff;
   logic          s2_valid_ff, s2_ok_ff;
   logic [63:0]   s2_count_ff, s2_count_in;
   logic [2:0]    s2_scale_ff;
   logic          s3_valid_ff, s3_ok_ff;
   logic [55:0]   s3_lo_ff, s3_lo_in;
   logic [31:0]   s3_hi_ff, s3_hi_in;
   logic [23:0]   s2_pow;
   logic          rsp_valid_ff;
   rsp_payload_type rsp_payload_ff, rsp_payload_in;

   // configuration port
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_field_ff        <= RST_START_FIELD;
         end_field_ff          <= RST_END_FIELD;
         leading_precision_ff  <= RST_LEADING_PRECISION;
         fraction_precision_ff <= RST_FRACTION_PRECISION;
      end else if (csr_write) begin
         case (csr_paddr[3:2])
            REG_START_FIELD:        start_field_ff        <= csr_pwdata[2:0];
            REG_END_FIELD:          end_field_ff          <= csr_pwdata[2:0];
            REG_LEADING_PRECISION:  leading_precision_ff  <= csr_pwdata[4:0];
            REG_FRACTION_PRECISION: fraction_precision_ff <= csr_pwdata[2:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[3:2])
         REG_START_FIELD:        csr_prdata = {29'd0, start_field_ff};
         REG_END_FIELD:          csr_prdata = {29'd0, end_field_ff};
         REG_LEADING_PRECISION:  csr_prdata = {27'd0, leading_precision_ff};
         REG_FRACTION_PRECISION: csr_prdata = {29'd0, fraction_precision_ff};
         default:                csr_prdata = '0;
      endcase
   end

   // qualifier check
   always_comb begin
      pair_ok = 1'b1;
      case ({start_field_ff, end_field_ff})
         {FIELD_YEAR, FIELD_YEAR}, {FIELD_MONTH, FIELD_MONTH}, {FIELD_DAY, FIELD_DAY},
         {FIELD_HOUR, FIELD_HOUR}, {FIELD_MINUTE, FIELD_MINUTE},
         {FIELD_FRACTION, FIELD_FRACTION}:
            prec = {1'b0, leading_precision_ff};
         {FIELD_YEAR, FIELD_MONTH}, {FIELD_DAY, FIELD_HOUR}, {FIELD_HOUR, FIELD_MINUTE}:
            prec = {1'b0, leading_precision_ff} + 6'd2;
         {FIELD_DAY, FIELD_MINUTE}:
            prec = {1'b0, leading_precision_ff} + 6'd4;
         {FIELD_SECOND, FIELD_SECOND}:
            prec = {1'b0, leading_precision_ff} + {3'd0, fraction_precision_ff};
         {FIELD_MINUTE, FIELD_SECOND}:
            prec = {1'b0, leading_precision_ff} + 6'd2 + {3'd0, fraction_precision_ff};
         {FIELD_HOUR, FIELD_SECOND}:
            prec = {1'b0, leading_precision_ff} + 6'd4 + {3'd0, fraction_precision_ff};
         {FIELD_DAY, FIELD_SECOND}:
            prec = {1'b0, leading_precision_ff} + 6'd5 + {3'd0, fraction_precision_ff};
         default: begin
            prec    = '0;
            pair_ok = 1'b0;
         end
      endcase
      qual_ok = pair_ok && (prec != 6'd0)
         && !(leading_precision_ff == 5'd0 && start_field_ff < FIELD_SECOND)
         && !(fraction_precision_ff != 3'd0 && end_field_ff < FIELD_SECOND)
         && !(int'(leading_precision_ff) > MAX_LEADING)
         && !(int'(fraction_precision_ff) > MAX_FRACTION);
   end

   // character parser
   assign c       = req_payload.text_char;
   assign sgn     = req_payload.sign_char;
   assign c_blank = (c == CHAR_SPACE) || (c == CHAR_TAB);
   assign c_digit = c inside {[CHAR_ZERO:CHAR_NINE]};
   assign frac_allowed = (end_field_ff >= FIELD_SECOND) && (start_field_ff != FIELD_FRACTION);

   always_comb begin
      phase_in           = phase_ff;
      field_index_in     = field_index_ff;
      field_value_in     = field_value_ff;
      digit_count_in     = digit_count_ff;
      fraction_digits_in = fraction_digits_ff;
      is_negative_in     = is_negative_ff;
      failed_in          = failed_ff;
      scale_in           = scale_ff;
      mul_en             = 1'b0;
      mul_k              = 6'd10;
      mul_add            = 7'd0;
      done               = 1'b0;
      lead_go            = 1'b0;
      fields_go          = 1'b0;

      if (!qual_ok) failed_in = 1'b1;

      if (!failed_in) begin
         if (phase_in == PH_START) begin
            if (sgn != CHAR_PLUS && sgn != CHAR_MINUS) begin
               failed_in = 1'b1;
               done      = 1'b1;
            end else begin
               is_negative_in = (sgn == CHAR_MINUS);
               phase_in       = PH_BLANK1;
            end
         end

         if (!done && phase_in == PH_BLANK1) begin
            if (c_blank) begin
               done = 1'b1;
            end else if (c == (is_negative_in ? CHAR_MINUS : CHAR_PLUS)) begin
               phase_in = PH_BLANK2;
               done     = 1'b1;
            end else begin
               lead_go = 1'b1;
            end
         end else if (!done && phase_in == PH_BLANK2) begin
            if (c_blank) done = 1'b1;
            else lead_go = 1'b1;
         end

         if (lead_go) begin
            if (leading_precision_ff != 5'd0) begin
               phase_in       = PH_LEAD;
               digit_count_in = 5'd0;
            end else begin
               fields_go = 1'b1;
            end
         end

         if (!done && phase_in == PH_LEAD) begin
            if (c_digit) begin
               if (digit_count_in >= leading_precision_ff) begin
                  failed_in = 1'b1;
               end else begin
                  mul_en         = 1'b1;
                  mul_k          = 6'd10;
                  mul_add        = {3'd0, c[3:0]};
                  digit_count_in = digit_count_in + 5'd1;
               end
               done = 1'b1;
            end else if (digit_count_in == 5'd0) begin
               failed_in = 1'b1;
               done      = 1'b1;
            end else begin
               fields_go = 1'b1;
            end
         end

         if (fields_go) begin
            field_index_in = start_field_ff + 3'd1;
            phase_in = (field_index_in <= end_field_ff) ? PH_PUNCT : PH_FRACSEL;
         end

         if (!done && phase_in == PH_FIELD) begin
            if (c_digit) begin
               if (digit_count_in >= 5'd2) begin
                  failed_in = 1'b1;
               end else begin
                  field_value_in = 7'(field_value_in * 7'd10 + {3'd0, c[3:0]});
                  digit_count_in = digit_count_in + 5'd1;
               end
               done = 1'b1;
            end else if (digit_count_in == 5'd0
                         || field_value_in > field_max(field_index_in)) begin
               failed_in = 1'b1;
               done      = 1'b1;
            end else begin
               mul_en         = 1'b1;
               mul_k          = 6'(field_max(field_index_in) + 7'd1);
               mul_add        = field_value_in;
               field_index_in = field_index_in + 3'd1;
               phase_in = (field_index_in <= end_field_ff) ? PH_PUNCT : PH_FRACSEL;
            end
         end

         if (!done && phase_in == PH_PUNCT) begin
            if (c == field_punc(field_index_in)
                || (field_index_in == FIELD_HOUR && c == CHAR_COLON)) begin
               phase_in       = PH_FIELD;
               field_value_in = 7'd0;
               digit_count_in = 5'd0;
            end else begin
               failed_in = 1'b1;
            end
            done = 1'b1;
         end

         if (!done && phase_in == PH_FRACSEL) begin
            if (frac_allowed && c == CHAR_DOT) begin
               phase_in = PH_FRACFIRST;
               done     = 1'b1;
            end else begin
               if (frac_allowed) scale_in = fraction_precision_ff;
               phase_in = PH_TRAIL;
            end
         end else if (!done && phase_in == PH_FRACFIRST) begin
            if (c_digit) begin
               phase_in           = PH_FRAC;
               fraction_digits_in = '0;
            end else begin
               scale_in = fraction_precision_ff;
               phase_in = PH_TRAIL;
            end
         end

         if (!done && phase_in == PH_FRAC) begin
            if (c_digit) begin
               if (int'(fraction_digits_in) >= MAX_FRACTION) begin
                  failed_in = 1'b1;
               end else begin
                  mul_en             = 1'b1;
                  mul_k              = 6'd10;
                  mul_add            = {3'd0, c[3:0]};
                  fraction_digits_in = fraction_digits_in + FDW'(1);
               end
               done = 1'b1;
            end else if (int'(fraction_digits_in) > int'(fraction_precision_ff)) begin
               failed_in = 1'b1;
               done      = 1'b1;
            end else begin
               scale_in = 3'(int'(fraction_precision_ff) - int'(fraction_digits_in));
               phase_in = PH_TRAIL;
            end
         end

         if (!done && phase_in == PH_TRAIL) begin
            if (!(c_blank || c == CHAR_NUL)) failed_in = 1'b1;
            done = 1'b1;
         end
      end
   end

   assign accum_in = mul_en ? accum_ff * {58'd0, mul_k} + {57'd0, mul_add} : accum_ff;

   // handshake
   always_comb begin
      rdy4       = !rsp_valid_ff || !rsp_stall;
      rdy3       = !s3_valid_ff || rdy4;
      rdy2       = !s2_valid_ff || rdy3;
      rdy1       = !s1_valid_ff || rdy2;
      req_stall  = !rdy1;
      req_accept = req_valid && rdy1;
      term_beat  = req_accept && (c == CHAR_NUL);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff           <= PH_START;
         accum_ff           <= '0;
         field_index_ff     <= '0;
         field_value_ff     <= '0;
         digit_count_ff     <= '0;
         fraction_digits_ff <= '0;
         is_negative_ff     <= 1'b0;
         failed_ff          <= 1'b0;
         scale_ff           <= '0;
      end else if (term_beat) begin
         phase_ff           <= PH_START;
         accum_ff           <= '0;
         field_index_ff     <= '0;
         field_value_ff     <= '0;
         digit_count_ff     <= '0;
         fraction_digits_ff <= '0;
         is_negative_ff     <= 1'b0;
         failed_ff          <= 1'b0;
         scale_ff           <= '0;
      end else if (req_accept) begin
         phase_ff           <= phase_in;
         accum_ff           <= accum_in;
         field_index_ff     <= field_index_in;
         field_value_ff     <= field_value_in;
         digit_count_ff     <= digit_count_in;
         fraction_digits_ff <= fraction_digits_in;
         is_negative_ff     <= is_negative_in;
         failed_ff          <= failed_in;
         scale_ff           <= scale_in;
      end
   end

   // result pipeline
   assign s2_count_in = !s1_ok_ff ? 64'd0 : (s1_neg_ff ? 64'd0 - s1_accum_ff : s1_accum_ff);
   assign s2_pow      = pow10(s2_scale_ff);
   assign s3_lo_in    = {24'd0, s2_count_ff[31:0]} * {32'd0, s2_pow};
   assign s3_hi_in    = 32'(s2_count_ff[63:32] * {8'd0, s2_pow});

   always_comb begin
      rsp_payload_in.interval_count = {s3_hi_ff, 32'd0} + {8'd0, s3_lo_ff};
      rsp_payload_in.is_valid       = s3_ok_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rdy1) s1_valid_ff  <= term_beat;
         if (rdy2) s2_valid_ff  <= s1_valid_ff;
         if (rdy3) s3_valid_ff  <= s2_valid_ff;
         if (rdy4) rsp_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy1) begin
         s1_accum_ff <= accum_in;
         s1_scale_ff <= scale_in;
         s1_neg_ff   <= is_negative_in;
         s1_ok_ff    <= !failed_in && (phase_in == PH_TRAIL);
      end
      if (rdy2) begin
         s2_count_ff <= s2_count_in;
         s2_scale_ff <= s1_scale_ff;
         s2_ok_ff    <= s1_ok_ff;
      end
      if (rdy3) begin
         s3_lo_ff <= s3_lo_in;
         s3_hi_ff <= s3_hi_in;
         s3_ok_ff <= s2_ok_ff;
      end
      if (rdy4) rsp_payload_ff <= rsp_payload_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule
